### rtl/assert_macros.svh
// Assertion macros for the rebuild stage; clk and rst_n are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the antecedent implies the consequent in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that the antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/png_unf_pkg.sv
// Shared types, constants and the Paeth predictor for the scanline unfilter.
package png_unf_pkg;

    // Default sizes and fixed limits
    localparam int MAX_ROW_PIXELS      = 2048;
    localparam int MAX_ROW_BYTES_DEF   = 16384;
    localparam int MAX_BPP_DEF         = 8;
    localparam int BPP_W               = 4;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CHANNELS     = 2'd0,
        CFG_WIDE_SAMPLES = 2'd1,
        CFG_ROW_PIXELS   = 2'd2,
        CFG_IMAGE_ROWS   = 2'd3
    } cfg_idx_t;

    // Row filter types
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_t;

    // Per-item control passed from the counter stage to the rebuild stage
    typedef struct packed {
        logic  is_data;
        filt_t filter;
        logic  flagged;
        logic  first_row;
        logic  first_pixel;
        logic  last_col;
        logic  last_row;
    } item_tag_t;

    // Paeth choice: smallest distance wins, ties go to left, then to above
    function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        logic signed [10:0] pa;
        logic signed [10:0] pb;
        logic signed [10:0] pc;
        logic [7:0]         pick;
        pa = $signed({3'b000, b}) - $signed({3'b000, c});
        pb = $signed({3'b000, a}) - $signed({3'b000, c});
        pc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
        if (pa < 0)
        begin
            pa = -pa;
        end
        if (pb < 0)
        begin
            pb = -pb;
        end
        if (pc < 0)
        begin
            pc = -pc;
        end
        if ((pa <= pb) && (pa <= pc))
        begin
            pick = a;
        end
        else if (pb <= pc)
        begin
            pick = b;
        end
        else
        begin
            pick = c;
        end
        return pick;
    endfunction

endpackage

### rtl/png_unf_line_mem.sv
// Previous-row line store: one write port, one registered read port.
module png_unf_line_mem #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Write the rebuilt byte, read the above byte for the next item
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/png_unf_ctrl.sv
// Configuration registers, row and column counters and per-item tagging.
module png_unf_ctrl #(
    parameter int MAX_ROW_BYTES = 16384,
    parameter int MAX_BPP       = 8,
    parameter int COL_W         = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [15:0]                   cfg_data,
    input  logic                          accept,
    input  logic [7:0]                    in_byte,
    output png_unf_pkg::item_tag_t        tag,
    output logic [COL_W-1:0]              col,
    output logic [png_unf_pkg::BPP_W-1:0] bpp
);
    import png_unf_pkg::*;

    localparam int NB_W = $clog2(MAX_ROW_BYTES + 1);

    logic [2:0]       channels_reg;
    logic             wide_reg;
    logic [11:0]      row_pixels_reg;
    logic [15:0]      image_rows_reg;

    logic [COL_W-1:0] column_reg;
    logic [COL_W-1:0] column_next;
    logic [15:0]      row_reg;
    logic [15:0]      row_next;
    logic             want_filter_reg;
    logic             want_filter_next;
    filt_t            filter_reg;
    filt_t            filter_next;
    logic             flagged_reg;
    logic             flagged_next;

    logic [2:0]       ch;
    logic [BPP_W-1:0] bpp_raw;
    logic [BPP_W-1:0] bpp_val;
    logic [11:0]      px;
    logic [15:0]      prod;
    logic [NB_W-1:0]  nbytes;
    logic [15:0]      rows;
    logic             last_col;
    logic             last_row;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channels_reg   <= 3'd3;
            wide_reg       <= 1'b0;
            row_pixels_reg <= 12'd1;
            image_rows_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CHANNELS:     channels_reg   <= cfg_data[2:0];
                CFG_WIDE_SAMPLES: wide_reg       <= cfg_data[0];
                CFG_ROW_PIXELS:   row_pixels_reg <= cfg_data[11:0];
                CFG_IMAGE_ROWS:   image_rows_reg <= cfg_data;
            endcase
        end
    end

    // Derive bytes per pixel, row bytes and row limit
    always_comb
    begin
        ch = channels_reg;
        if (ch == 3'd0)
        begin
            ch = 3'd1;
        end
        else if (ch > 3'd4)
        begin
            ch = 3'd4;
        end
        bpp_raw = wide_reg ? {ch, 1'b0} : {1'b0, ch};
        bpp_val = bpp_raw;
        if (32'(bpp_raw) > MAX_BPP)
        begin
            bpp_val = BPP_W'(MAX_BPP);
        end
        px = (row_pixels_reg == 12'd0) ? 12'd1 : row_pixels_reg;
        if (32'(px) > MAX_ROW_PIXELS)
        begin
            px = 12'(MAX_ROW_PIXELS);
        end
        prod = 16'(px) * 16'(bpp_val);
        if (32'(prod) > MAX_ROW_BYTES)
        begin
            nbytes = NB_W'(MAX_ROW_BYTES);
        end
        else
        begin
            nbytes = NB_W'(prod);
        end
        rows = (image_rows_reg == 16'd0) ? 16'd1 : image_rows_reg;
    end

    // Tag the item and advance the counters
    always_comb
    begin
        last_col = (32'(column_reg) + 32'd1) >= 32'(nbytes);
        last_row = last_col && ((17'(row_reg) + 17'd1) >= 17'(rows));

        tag.is_data     = !want_filter_reg;
        tag.filter      = filter_reg;
        tag.flagged     = flagged_reg;
        tag.first_row   = (row_reg == 16'd0);
        tag.first_pixel = 32'(column_reg) < 32'(bpp_val);
        tag.last_col    = last_col;
        tag.last_row    = last_row;

        column_next      = column_reg;
        row_next         = row_reg;
        want_filter_next = want_filter_reg;
        filter_next      = filter_reg;
        flagged_next     = flagged_reg;

        if (accept)
        begin
            if (want_filter_reg)
            begin
                if (in_byte > 8'd4)
                begin
                    filter_next  = FILT_NONE;
                    flagged_next = 1'b1;
                end
                else
                begin
                    filter_next  = filt_t'(in_byte[2:0]);
                    flagged_next = 1'b0;
                end
                want_filter_next = 1'b0;
                column_next      = '0;
            end
            else if (last_col)
            begin
                column_next      = '0;
                want_filter_next = 1'b1;
                row_next         = last_row ? 16'd0 : row_reg + 16'd1;
            end
            else
            begin
                column_next = column_reg + COL_W'(1);
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg      <= '0;
            row_reg         <= '0;
            want_filter_reg <= 1'b1;
            filter_reg      <= FILT_NONE;
            flagged_reg     <= 1'b0;
        end
        else
        begin
            column_reg      <= column_next;
            row_reg         <= row_next;
            want_filter_reg <= want_filter_next;
            filter_reg      <= filter_next;
            flagged_reg     <= flagged_next;
        end
    end

    assign col = column_reg;
    assign bpp = bpp_val;

endmodule

### rtl/png_unf_recon.sv
// Rebuild stage: predictor, left and upper-left history, output register.
module png_unf_recon #(
    parameter int MAX_BPP = 8,
    parameter int COL_W   = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  png_unf_pkg::item_tag_t        tag_in,
    input  logic [COL_W-1:0]              col_in,
    input  logic [7:0]                    byte_in,
    input  logic [7:0]                    rd_data,
    input  logic [png_unf_pkg::BPP_W-1:0] bpp,
    output logic                          ready,
    output logic                          we,
    output logic [COL_W-1:0]              waddr,
    output logic [7:0]                    wdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    pixel_byte,
    output logic                          bad_filter,
    output logic                          row_end,
    output logic                          image_end
);
    import png_unf_pkg::*;

    `include "assert_macros.svh"

    localparam int LI_W = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;

    logic             s1_valid_reg;
    item_tag_t        s1_tag_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [7:0]       s1_byte_reg;
    logic [7:0]       left_reg [MAX_BPP];
    logic [7:0]       upleft_reg [MAX_BPP];

    logic             out_valid_reg;
    logic [7:0]       pixel_reg;
    logic             bad_reg;
    logic             row_end_reg;
    logic             image_end_reg;

    logic             s1_advance;
    logic             s1_emit;
    logic [LI_W-1:0]  tap;
    logic [7:0]       a;
    logic [7:0]       b;
    logic [7:0]       c;
    logic [8:0]       sum_ab;
    logic [7:0]       pred;
    logic [7:0]       res;

    function automatic logic [7:0] byte_in_sum(logic [7:0] x, logic [7:0] p);
        return x + p;
    endfunction

    // Stage moves on when it carries a filter byte or the output slot frees
    assign s1_advance = !s1_tag_reg.is_data || !out_valid_reg || out_ready;
    assign ready      = !s1_valid_reg || s1_advance;
    assign s1_emit    = s1_valid_reg && s1_tag_reg.is_data && s1_advance;

    // Form neighbours and predictor
    always_comb
    begin
        tap    = LI_W'(bpp - BPP_W'(1));
        a      = s1_tag_reg.first_pixel ? 8'd0 : left_reg[tap];
        b      = s1_tag_reg.first_row ? 8'd0 : rd_data;
        c      = (s1_tag_reg.first_row || s1_tag_reg.first_pixel) ? 8'd0 : upleft_reg[tap];
        sum_ab = {1'b0, a} + {1'b0, b};
        unique case (s1_tag_reg.filter)
            FILT_NONE:  pred = 8'd0;
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = sum_ab[8:1];
            FILT_PAETH: pred = paeth_pick(a, b, c);
            default:    pred = 8'd0;
        endcase
        res = byte_in_sum(s1_byte_reg, pred);
    end

    // Hold the item under work
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_tag_reg   <= '0;
        end
        else if (take)
        begin
            s1_valid_reg <= 1'b1;
            s1_tag_reg   <= tag_in;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_col_reg  <= col_in;
            s1_byte_reg <= byte_in;
        end
    end

    // Shift rebuilt and above bytes, clear at each row start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_BPP; i++)
            begin
                left_reg[i]   <= 8'd0;
                upleft_reg[i] <= 8'd0;
            end
        end
        else if (s1_valid_reg && s1_advance)
        begin
            if (s1_tag_reg.is_data)
            begin
                left_reg[0]   <= res;
                upleft_reg[0] <= b;
                for (int i = 1; i < MAX_BPP; i++)
                begin
                    left_reg[i]   <= left_reg[i-1];
                    upleft_reg[i] <= upleft_reg[i-1];
                end
            end
            else
            begin
                for (int i = 0; i < MAX_BPP; i++)
                begin
                    left_reg[i]   <= 8'd0;
                    upleft_reg[i] <= 8'd0;
                end
            end
        end
    end

    // Load the output register, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_emit)
        begin
            pixel_reg     <= res;
            bad_reg       <= s1_tag_reg.flagged;
            row_end_reg   <= s1_tag_reg.last_col;
            image_end_reg <= s1_tag_reg.last_row;
        end
    end

    assign we         = s1_emit;
    assign waddr      = s1_col_reg;
    assign wdata      = res;
    assign out_valid  = out_valid_reg;
    assign pixel_byte = pixel_reg;
    assign bad_filter = bad_reg;
    assign row_end    = row_end_reg;
    assign image_end  = image_end_reg;

    // A fresh result comes only from a data item that left the stage
    `ASSERT_IMPL(a_out_from_data, $rose(out_valid_reg), $past(s1_emit))
    // The image ends only on the end of a row
    `ASSERT_IMPL(a_image_end_row, out_valid_reg && image_end_reg, row_end_reg)
    // A stalled stage keeps its item
    `ASSERT_NEXT(a_stall_holds, s1_valid_reg && !s1_advance, s1_valid_reg && $stable(s1_tag_reg))

endmodule

### rtl/png_scanline_unfilter_core.sv
// Top level of the PNG scanline unfilter: counters, line store and rebuild stage.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------------
//  input    | in_valid / in_ready | stream_byte
//  output   | out_valid/out_ready | pixel_byte, bad_filter, row_end, image_end
//  config   | cfg_we              | cfg_index, cfg_data
//
// One byte is taken every cycle while the rebuild stage can move on. A data byte
// is registered into the rebuild stage and rebuilt with the registered line
// store read, addressed by the column count when the byte is taken; the result
// is then loaded into the output register. Reset clears counters and history;
// the line store keeps no reset, and its data is unused on the first row. With
// out_ready low the result holds; one more byte is taken before in_ready drops.
module png_scanline_unfilter_core #(
    parameter int MAX_ROW_BYTES = png_unf_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_BPP       = png_unf_pkg::MAX_BPP_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  stream_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  pixel_byte,
    output logic        bad_filter,
    output logic        row_end,
    output logic        image_end
);
    import png_unf_pkg::*;

    localparam int COL_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

    logic             accept;
    item_tag_t        tag;
    logic [COL_W-1:0] col;
    logic [BPP_W-1:0] bpp;
    logic [7:0]       rd_data;
    logic             we;
    logic [COL_W-1:0] waddr;
    logic [7:0]       wdata;

    assign accept = in_valid && in_ready;

    // Count rows and columns, tag each item
    png_unf_ctrl #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_BPP       (MAX_BPP),
        .COL_W         (COL_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .in_byte   (stream_byte),
        .tag       (tag),
        .col       (col),
        .bpp       (bpp)
    );

    // Hold the previous row
    png_unf_line_mem #(
        .DEPTH (MAX_ROW_BYTES),
        .AW    (COL_W)
    ) u_line_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (accept),
        .raddr (col),
        .rdata (rd_data)
    );

    // Rebuild each data byte
    png_unf_recon #(
        .MAX_BPP (MAX_BPP),
        .COL_W   (COL_W)
    ) u_recon (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (accept),
        .tag_in     (tag),
        .col_in     (col),
        .byte_in    (stream_byte),
        .rd_data    (rd_data),
        .bpp        (bpp),
        .ready      (in_ready),
        .we         (we),
        .waddr      (waddr),
        .wdata      (wdata),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_byte (pixel_byte),
        .bad_filter (bad_filter),
        .row_end    (row_end),
        .image_end  (image_end)
    );

endmodule

### test/png_scanline_unfilter_core_test.sv
// Self-checking testbench for the PNG scanline unfilter core.
module png_scanline_unfilter_core_test;
    import png_unf_pkg::*;

    localparam int MAX_LINE     = MAX_ROW_BYTES_DEF;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_WAIT  = 6;
    localparam int SETTING_FILL = 60;

    // Filter type bytes outside the defined set
    localparam logic [7:0] FIRST_BAD_FILTER = 8'd5;
    localparam logic [7:0] LAST_BAD_FILTER  = 8'hFF;

    typedef struct packed {
        logic [7:0] value;
        logic       bad;
        logic       last_in_row;
        logic       last_in_image;
    } pixel_t;

    // Track the rebuilt image and hold the pixels still owed by the block
    class pixel_rebuilder;
        logic [2:0]  chan_reg;
        logic        wide_reg;
        logic [11:0] px_reg;
        logic [15:0] rows_reg;
        logic [7:0]  line_mem [MAX_LINE];
        logic [7:0]  left_hist [8];
        logic [7:0]  upleft_hist [8];
        int          col_cnt;
        int          row_cnt;
        bit          want_filter;
        filt_t       row_mode;
        bit          row_bad;
        pixel_t      pending_pixels [$];
        int          errors;

        function new();
            chan_reg    = 3'd3;
            wide_reg    = 1'b0;
            px_reg      = 12'd1;
            rows_reg    = 16'd1;
            col_cnt     = 0;
            row_cnt     = 0;
            want_filter = 1'b1;
            row_mode    = FILT_NONE;
            row_bad     = 1'b0;
            errors      = 0;
            foreach (left_hist[i])
            begin
                left_hist[i]   = 8'd0;
                upleft_hist[i] = 8'd0;
            end
        endfunction

        function void set_reg(cfg_idx_t idx, logic [15:0] data);
            case (idx)
                CFG_CHANNELS:     chan_reg = data[2:0];
                CFG_WIDE_SAMPLES: wide_reg = data[0];
                CFG_ROW_PIXELS:   px_reg   = data[11:0];
                CFG_IMAGE_ROWS:   rows_reg = data;
                default:          ;
            endcase
        endfunction

        function int pixel_bytes();
            int ch;
            ch = chan_reg;
            if (ch == 0)
            begin
                ch = 1;
            end
            if (ch > 4)
            begin
                ch = 4;
            end
            return ch * (wide_reg ? 2 : 1);
        endfunction

        function int row_len();
            int px;
            int n;
            px = px_reg;
            if (px == 0)
            begin
                px = 1;
            end
            if (px > MAX_ROW_PIXELS)
            begin
                px = MAX_ROW_PIXELS;
            end
            n = px * pixel_bytes();
            return (n > MAX_LINE) ? MAX_LINE : n;
        endfunction

        function int rows_per_image();
            return (rows_reg == 16'd0) ? 1 : int'(rows_reg);
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        // Pick the neighbour closest to the gradient estimate a + b - c
        function int paeth_choice(int a, int b, int c);
            int da;
            int db;
            int dc;
            da = (b > c) ? b - c : c - b;
            db = (a > c) ? a - c : c - a;
            dc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
            if (da <= db && da <= dc)
            begin
                return a;
            end
            if (db <= dc)
            begin
                return b;
            end
            return c;
        endfunction

        // Rebuild one stream byte; filter type bytes only set up the row
        function void take_stream_byte(logic [7:0] x);
            int     bpp;
            int     len;
            int     a;
            int     b;
            int     c;
            int     pred;
            bit     first_row;
            bit     first_px;
            pixel_t want;
            if (want_filter)
            begin
                if (x > FILT_PAETH)
                begin
                    row_mode = FILT_NONE;
                    row_bad  = 1'b1;
                end
                else
                begin
                    row_mode = filt_t'(x[2:0]);
                    row_bad  = 1'b0;
                end
                want_filter = 1'b0;
                col_cnt     = 0;
                foreach (left_hist[i])
                begin
                    left_hist[i]   = 8'd0;
                    upleft_hist[i] = 8'd0;
                end
                return;
            end
            bpp       = pixel_bytes();
            len       = row_len();
            first_row = (row_cnt == 0);
            first_px  = (col_cnt < bpp);
            a = first_px ? 0 : int'(left_hist[bpp - 1]);
            b = (first_row || col_cnt >= MAX_LINE) ? 0 : int'(line_mem[col_cnt]);
            c = (first_row || first_px) ? 0 : int'(upleft_hist[bpp - 1]);
            case (row_mode)
                FILT_SUB:   pred = a;
                FILT_UP:    pred = b;
                FILT_AVG:   pred = (a + b) >> 1;
                FILT_PAETH: pred = paeth_choice(a, b, c);
                default:    pred = 0;
            endcase
            want.value = x + pred[7:0];
            want.bad   = row_bad;
            // Save the byte for the next row and shift the neighbour history
            if (col_cnt < MAX_LINE)
            begin
                line_mem[col_cnt] = want.value;
            end
            for (int i = 7; i > 0; i--)
            begin
                left_hist[i]   = left_hist[i - 1];
                upleft_hist[i] = upleft_hist[i - 1];
            end
            left_hist[0]   = want.value;
            upleft_hist[0] = b[7:0];
            want.last_in_row   = (col_cnt + 1 >= len);
            want.last_in_image = want.last_in_row && (row_cnt + 1 >= rows_per_image());
            pending_pixels.push_back(want);
            // Advance the counters, restarting after the final image byte
            if (want.last_in_row)
            begin
                col_cnt     = 0;
                want_filter = 1'b1;
                row_cnt     = want.last_in_image ? 0 : ((row_cnt + 1) & 16'hFFFF);
            end
            else
            begin
                col_cnt = (col_cnt + 1) & 14'h3FFF;
            end
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void match_pixel(logic [7:0] value, logic bad, logic rend, logic iend);
            pixel_t want;
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: pixel_byte expected none actual %h", $time, value);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            compare_field("pixel_byte", want.value, value);
            compare_field("bad_filter", 8'(want.bad), 8'(bad));
            compare_field("row_end", 8'(want.last_in_row), 8'(rend));
            compare_field("image_end", 8'(want.last_in_image), 8'(iend));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  stream_byte;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  pixel_byte;
    logic        bad_filter;
    logic        row_end;
    logic        image_end;

    pixel_rebuilder rebuilt;
    int             in_gap_pct    = 31;
    int             out_stall_pct = 52;
    int             quiet_cycles  = 0;

    png_scanline_unfilter_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .stream_byte(stream_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_byte (pixel_byte),
        .bad_filter (bad_filter),
        .row_end    (row_end),
        .image_end  (image_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    // Feed every accepted item to the tracker and check every result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                rebuilt.take_stream_byte(stream_byte);
            end
            if (out_valid && out_ready)
            begin
                rebuilt.match_pixel(pixel_byte, bad_filter, row_end, image_end);
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one item, with a random gap ahead of it, and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < in_gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < in_gap_pct);
        end
        in_valid    <= 1'b1;
        stream_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid and wait until every pixel owed has come out
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (rebuilt.pending() != 0);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        rebuilt.set_reg(idx, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly defined filter types, now and then one out of range
    function automatic logic [7:0] pick_filter();
        int r;
        r = $urandom_range(0, 19);
        if (r < 17)
        begin
            return 8'(r % 5);
        end
        if (r == 17)
        begin
            return FIRST_BAD_FILTER;
        end
        return 8'($urandom_range(FIRST_BAD_FILTER, LAST_BAD_FILTER));
    endfunction

    // Lean toward extremes and small values so Paeth ties show up
    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'($urandom_range(0, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_image(output int n);
        int rows;
        int len;
        rows = rebuilt.rows_per_image();
        len  = rebuilt.row_len();
        n    = 0;
        for (int r = 0; r < rows; r++)
        begin
            send_byte(pick_filter());
            n++;
            for (int i = 0; i < len; i++)
            begin
                send_byte(pick_data());
                n++;
            end
        end
    endtask

    // Small random image shape, with junk in the unused register bits
    task automatic pick_setting();
        logic [15:0] junk;
        junk = 16'($urandom);
        write_reg(CFG_CHANNELS, {junk[15:3], 3'($urandom_range(0, 7))});
        write_reg(CFG_WIDE_SAMPLES, {junk[15:1], 1'($urandom_range(0, 1))});
        write_reg(CFG_ROW_PIXELS, {junk[15:12],
                  12'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6))});
        write_reg(CFG_IMAGE_ROWS, 16'($urandom_range(0, 4)));
    endtask

    task automatic run_directed();
        logic [7:0] corner [8];
        corner = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h7F, 8'h55, 8'hAA};
        // Reset shape: one row of three bytes, all in the first pixel
        send_byte(8'(FILT_SUB));
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h80);
        settle();
        // Eight bytes per pixel, zero size registers, top filter type byte
        write_reg(CFG_CHANNELS, 16'd7);
        write_reg(CFG_WIDE_SAMPLES, 16'd1);
        write_reg(CFG_ROW_PIXELS, 16'd0);
        write_reg(CFG_IMAGE_ROWS, 16'd0);
        send_byte(LAST_BAD_FILTER);
        foreach (corner[i])
        begin
            send_byte(corner[i]);
        end
        settle();
        // Tall image cut short by a shape change in mid row
        write_reg(CFG_CHANNELS, 16'd0);
        write_reg(CFG_WIDE_SAMPLES, 16'd0);
        write_reg(CFG_ROW_PIXELS, 16'd3);
        write_reg(CFG_IMAGE_ROWS, 16'hFFFF);
        send_byte(8'(FILT_NONE));
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'(FILT_PAETH));
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'(FILT_UP));
        send_byte(8'h01);
        settle();
        write_reg(CFG_ROW_PIXELS, 16'd1);
        write_reg(CFG_IMAGE_ROWS, 16'd1);
        send_byte(8'h7F);
        // Fresh image after the restart
        send_byte(8'(FILT_AVG));
        send_byte(8'h80);
        settle();
    endtask

    initial
    begin
        int n;
        int sent;
        rebuilt     = new();
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_CHANNELS;
        cfg_data    = 16'd0;
        in_valid    = 1'b0;
        stream_byte = 8'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Random images under three idling patterns
        for (int regime = 0; regime < 3; regime++)
        begin
            in_gap_pct    = (regime == 0) ? 31 : (regime == 1) ? 52 : 0;
            out_stall_pct = (regime == 0) ? 52 : (regime == 1) ? 31 : 0;
            for (int s = 0; s < 4; s++)
            begin
                pick_setting();
                sent = 0;
                while (sent < SETTING_FILL)
                begin
                    send_image(n);
                    sent += n;
                end
                settle();
            end
        end

        if (rebuilt.errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
